/* rtl/core/hcbd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hcbd_pkg
// Shared types, codes and helpers for the chunked body decoder.
// ----------------------------------------------------------------------------
package hcbd_pkg;

  localparam int SIZE_BITS = 32;

  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_MISSING  = 3'd1,
    ERR_TRUNC    = 3'd2,
    ERR_END      = 3'd3,
    ERR_OVERFLOW = 3'd4
  } err_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] b);
    hex_t h;
    h.ok  = 1'b0;
    h.val = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      h.ok  = 1'b1;
      h.val = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      h.ok  = 1'b1;
      h.val = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      h.ok  = 1'b1;
      h.val = 4'(b - 8'h37);
    end
    return h;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/http_chunked_body_decoder.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// Strips chunked transfer framing from a body byte stream, passing payload
// bytes and reporting completion or framing errors.
// ----------------------------------------------------------------------------
// A result is registered and appears on out_* in the cycle after its word is accepted.
// Throughput: one word per cycle; in_ready drops only while a result is held
// and out_ready is low (single output register).
// Reset (synchronous, rst_n low): parser returns to the start of a size line,
// output register empties.
module http_chunked_body_decoder (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_action,
  input  wire logic [7:0]           in_byte_in,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [1:0]                out_kind,
  output logic [7:0]                out_data_out,
  output logic [2:0]                out_error_code
);
  import hcbd_pkg::*;

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_DIGITS = 3'd1,
    PH_DATA   = 3'd2,
    PH_TRAIL1 = 3'd3,
    PH_TRAIL2 = 3'd4,
    PH_DONE   = 3'd5,
    PH_ERROR  = 3'd6
  } phase_t;

  phase_t                 phase_r, phase_nxt;
  logic [SIZE_BITS-1:0]   chunk_size_r, chunk_size_nxt;
  logic [SIZE_BITS-1:0]   bytes_left_r, bytes_left_nxt;
  logic                   digits_ended_r, digits_ended_nxt;

  logic                   out_valid_r;
  kind_t                  kind_r;
  logic [7:0]             data_r;
  err_t                   err_r;

  logic                   res_valid;
  kind_t                  res_kind;
  logic [7:0]             res_data;
  err_t                   res_err;

  logic                   in_accept;
  hex_t                   hex;
  logic                   size_full;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;
  assign hex       = hex_decode(in_byte_in);
  // another digit would shift set bits out of the top
  assign size_full = (chunk_size_r[SIZE_BITS-1 -: 4] != 4'd0);

  always_comb begin
    phase_nxt        = phase_r;
    chunk_size_nxt   = chunk_size_r;
    bytes_left_nxt   = bytes_left_r;
    digits_ended_nxt = digits_ended_r;
    res_valid        = 1'b0;
    res_kind         = KIND_DATA;
    res_data         = 8'd0;
    res_err          = ERR_NONE;

    if (in_accept && phase_r != PH_DONE && phase_r != PH_ERROR) begin
      if (in_action) begin
        phase_nxt = PH_ERROR;
        res_valid = 1'b1;
        res_kind  = KIND_ERROR;
        res_err   = ERR_TRUNC;
      end else begin
        case (phase_r)
          PH_START: begin
            if (in_byte_in != CHAR_SPACE && in_byte_in != CHAR_TAB) begin
              if (!hex.ok) begin
                phase_nxt = PH_ERROR;
                res_valid = 1'b1;
                res_kind  = KIND_ERROR;
                res_err   = ERR_MISSING;
              end else if (size_full) begin
                phase_nxt = PH_ERROR;
                res_valid = 1'b1;
                res_kind  = KIND_ERROR;
                res_err   = ERR_OVERFLOW;
              end else begin
                chunk_size_nxt = {chunk_size_r[SIZE_BITS-5:0], hex.val};
                phase_nxt      = PH_DIGITS;
              end
            end
          end
          PH_DIGITS: begin
            if (in_byte_in == CHAR_LF) begin
              if (chunk_size_r == '0) begin
                phase_nxt = PH_DONE;
                res_valid = 1'b1;
                res_kind  = KIND_DONE;
              end else begin
                bytes_left_nxt = chunk_size_r;
                phase_nxt      = PH_DATA;
              end
            end else if (!digits_ended_r) begin
              if (!hex.ok) begin
                // extension or junk: ignore the rest of the line
                digits_ended_nxt = 1'b1;
              end else if (size_full) begin
                phase_nxt = PH_ERROR;
                res_valid = 1'b1;
                res_kind  = KIND_ERROR;
                res_err   = ERR_OVERFLOW;
              end else begin
                chunk_size_nxt = {chunk_size_r[SIZE_BITS-5:0], hex.val};
              end
            end
          end
          PH_DATA: begin
            bytes_left_nxt = bytes_left_r - SIZE_BITS'(1);
            if (bytes_left_r == SIZE_BITS'(1)) begin
              phase_nxt = PH_TRAIL1;
            end
            res_valid = 1'b1;
            res_kind  = KIND_DATA;
            res_data  = in_byte_in;
          end
          PH_TRAIL1: begin
            phase_nxt = PH_TRAIL2;
          end
          PH_TRAIL2: begin
            if (in_byte_in != CHAR_LF) begin
              phase_nxt = PH_ERROR;
              res_valid = 1'b1;
              res_kind  = KIND_ERROR;
              res_err   = ERR_END;
            end else begin
              chunk_size_nxt   = '0;
              digits_ended_nxt = 1'b0;
              phase_nxt        = PH_START;
            end
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_START;
      chunk_size_r   <= '0;
      bytes_left_r   <= '0;
      digits_ended_r <= 1'b0;
      out_valid_r    <= 1'b0;
      kind_r         <= KIND_DATA;
      data_r         <= 8'd0;
      err_r          <= ERR_NONE;
    end else begin
      phase_r        <= phase_nxt;
      chunk_size_r   <= chunk_size_nxt;
      bytes_left_r   <= bytes_left_nxt;
      digits_ended_r <= digits_ended_nxt;
      if (in_ready) begin
        out_valid_r <= res_valid;
        kind_r      <= res_kind;
        data_r      <= res_data;
        err_r       <= res_err;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = kind_r;
  assign out_data_out   = data_r;
  assign out_error_code = err_r;

  // terminal phases never exit without reset
  a_done_sticky : assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DONE || phase_r == PH_ERROR) |=> (phase_r == $past(phase_r)))
    else $error("terminal phase left");

  // a payload phase always has bytes outstanding
  a_data_count : assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (bytes_left_r != '0))
    else $error("payload phase with zero count");

  // error results carry a code, other results do not
  a_err_code : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((kind_r == KIND_ERROR) == (err_r != ERR_NONE)))
    else $error("error code does not match kind");

  // a done or error result is always followed by a terminal phase
  a_final_phase : assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && res_valid && res_kind != KIND_DATA) |=>
      (phase_r == PH_DONE || phase_r == PH_ERROR))
    else $error("final result without terminal phase");

endmodule
`default_nettype wire
